// ===== hw/rtl/tasg_pkg.sv =====
// Shared types and constants for the three-axis step/direction generator.
// No dependencies; imported by tasg_axis and the top level.
package tasg_pkg;

  localparam int PosW     = 16;
  localparam int PeriodW  = 16;
  localparam int ElapsedW = 17;
  localparam int HeightW  = 15;
  localparam int CfgIdxW  = 2;

  localparam logic [ElapsedW-1:0] ElapsedMax = '1;

  localparam logic [PeriodW-1:0] ZPeriodRst       = 16'd1000;
  localparam logic [PeriodW-1:0] PlatterPeriodRst = 16'd12000;
  localparam logic [PeriodW-1:0] TurretPeriodRst  = 16'd10000;
  localparam logic [HeightW-1:0] ZMaxHeightRst    = 15'd12000;

  typedef enum logic [1:0] {
    REQ_TICK        = 2'd0,
    REQ_SET_Z       = 2'd1,
    REQ_SET_PLATTER = 2'd2,
    REQ_SET_TURRET  = 2'd3
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_Z_PERIOD       = 2'd0,
    CFG_PLATTER_PERIOD = 2'd1,
    CFG_TURRET_PERIOD  = 2'd2,
    CFG_Z_MAX_HEIGHT   = 2'd3
  } cfg_idx_e;

  // Per-axis command for one processed word.
  typedef struct packed {
    logic tick;
    logic set_goal;
  } axis_ctl_t;

endpackage

// ===== hw/rtl/tasg_axis.sv =====
// One stepper axis: goal, position, elapsed counter and step/dir line state.
// Depends on tasg_pkg.
module tasg_axis import tasg_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  axis_ctl_t              ctl_i,
  input  logic signed [PosW-1:0] goal_i,
  input  logic [PeriodW-1:0]     period_i,
  output logic                   step_o,
  output logic                   dir_o,
  output logic                   done_o,
  output logic signed [PosW-1:0] pos_o
);

  logic signed [PosW-1:0] goal_q, goal_d;
  logic signed [PosW-1:0] now_q, now_d;
  logic [ElapsedW-1:0]    elapsed_q, elapsed_d;
  logic                   step_q, step_d;
  logic                   dir_q, dir_d;

  logic [ElapsedW-1:0] elapsed_inc;
  logic                dir_up;
  logic                fire;

  always_comb begin
    elapsed_inc = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + 1'b1;
    dir_up      = goal_q > now_q;
    fire        = ctl_i.tick && (goal_q != now_q) && (elapsed_inc > {1'b0, period_i});

    goal_d    = goal_q;
    now_d     = now_q;
    elapsed_d = elapsed_q;
    step_d    = step_q;
    dir_d     = dir_q;

    if (ctl_i.set_goal) begin
      goal_d = goal_i;
    end
    if (ctl_i.tick) begin
      elapsed_d = elapsed_inc;
    end
    if (fire) begin
      dir_d     = dir_up;
      elapsed_d = '0;
      step_d    = ~step_q;
      now_d     = dir_up ? now_q + 16'sd1 : now_q - 16'sd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q    <= '0;
      now_q     <= '0;
      elapsed_q <= '0;
      step_q    <= 1'b0;
      dir_q     <= 1'b0;
    end else begin
      goal_q    <= goal_d;
      now_q     <= now_d;
      elapsed_q <= elapsed_d;
      step_q    <= step_d;
      dir_q     <= dir_d;
    end
  end

  assign step_o = step_q;
  assign dir_o  = dir_q;
  assign done_o = (goal_q == now_q);
  assign pos_o  = now_q;

  // Every position change is one toggle of the step line, and vice versa.
  a_step_tracks_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((now_q != $past(now_q)) == (step_q != $past(step_q))))
    else $error("step toggle and position change out of sync");

  a_idle_at_goal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.tick && (goal_q == now_q)) |=> ($stable(step_q) && $stable(now_q)))
    else $error("axis stepped while at its goal");

  a_no_tick_no_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.tick |=> ($stable(elapsed_q) && $stable(now_q) && $stable(dir_q)))
    else $error("axis moved without a tick");

endmodule

// ===== hw/rtl/three_axis_stepper_step_generator_unit.sv =====
// Top level of the three-axis step/direction generator (z, platter, turret).
// Depends on tasg_pkg and tasg_axis.
//
// Usage:
//   Slave channel s_axis_*: one word per request. tuser carries the request
//   kind (tick, set z goal, set platter goal, set turret goal), tdata the
//   signed target, ignored on a tick.
//   Master channel m_axis_*: one word per request with the line levels, done
//   flags and positions of all three axes after that request.
//   Config port: cfg_we_i/cfg_idx_i/cfg_wdata_i write the three step periods
//   and the z height clamp; write only while no word is in flight.
// Throughput: one word per cycle while the master side takes results; each
// word goes from the input register through one update of the axis state,
// which doubles as the result register presented on m_axis.
// Stall: while the master side is held, the result holds and the input
// register keeps one more word; s_axis_tready drops only when both are full.
// Reset: goals, positions, counters and lines go to zero, periods and clamp
// to their defaults, both channels empty.
module three_axis_stepper_step_generator_unit import tasg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [15:0]        s_axis_tdata_i,   // [15:0] target_value
  input  logic [1:0]         s_axis_tuser_i,   // [1:0] req_type
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [0] z_step [1] z_dir [2] platter step line [3] platter direction
  // [4] turret step line [5] turret direction [6] z_done [7] platter_done
  // [8] turret_done [24:9] z_position [40:25] platter_position
  // [56:41] turret_position [63:57] 0
  output logic [63:0]        m_axis_tdata_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [PeriodW-1:0] cfg_wdata_i
);

  logic                   in_v_q, in_v_d;
  req_type_e              req_q;
  logic signed [PosW-1:0] tgt_q;
  logic                   out_v_q, out_v_d;
  logic                   accept;
  logic                   adv;

  logic [PeriodW-1:0] z_period_q, platter_period_q, turret_period_q;
  logic [HeightW-1:0] z_max_q;

  logic signed [PosW-1:0] z_goal;
  axis_ctl_t              z_ctl, platter_ctl, turret_ctl;

  logic                   z_step, z_dir, z_done;
  logic                   plat_step, plat_dir, platter_done;
  logic                   turr_step, turr_dir, turret_done;
  logic signed [PosW-1:0] z_pos, platter_pos, turret_pos;

  // Advance the held word into the axis state when the result slot frees up.
  assign adv             = in_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_v_q || adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_v_d = in_v_q;
    if (accept) begin
      in_v_d = 1'b1;
    end else if (adv) begin
      in_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (adv) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_e'(s_axis_tuser_i);
      tgt_q <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_period_q       <= ZPeriodRst;
      platter_period_q <= PlatterPeriodRst;
      turret_period_q  <= TurretPeriodRst;
      z_max_q          <= ZMaxHeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_Z_PERIOD:       z_period_q       <= cfg_wdata_i;
        CFG_PLATTER_PERIOD: platter_period_q <= cfg_wdata_i;
        CFG_TURRET_PERIOD:  turret_period_q  <= cfg_wdata_i;
        CFG_Z_MAX_HEIGHT:   z_max_q          <= cfg_wdata_i[HeightW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp z goal to [0, z_max]; a non-negative target fits in HeightW bits.
  always_comb begin
    if (tgt_q[PosW-1]) begin
      z_goal = '0;
    end else if (tgt_q[HeightW-1:0] > z_max_q) begin
      z_goal = {1'b0, z_max_q};
    end else begin
      z_goal = tgt_q;
    end
  end

  always_comb begin
    z_ctl.tick           = adv && (req_q == REQ_TICK);
    z_ctl.set_goal       = adv && (req_q == REQ_SET_Z);
    platter_ctl.tick     = z_ctl.tick;
    platter_ctl.set_goal = adv && (req_q == REQ_SET_PLATTER);
    turret_ctl.tick      = z_ctl.tick;
    turret_ctl.set_goal  = adv && (req_q == REQ_SET_TURRET);
  end

  tasg_axis u_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (z_ctl),
    .goal_i   (z_goal),
    .period_i (z_period_q),
    .step_o   (z_step),
    .dir_o    (z_dir),
    .done_o   (z_done),
    .pos_o    (z_pos)
  );

  tasg_axis u_platter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (platter_ctl),
    .goal_i   (tgt_q),
    .period_i (platter_period_q),
    .step_o   (plat_step),
    .dir_o    (plat_dir),
    .done_o   (platter_done),
    .pos_o    (platter_pos)
  );

  tasg_axis u_turret (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (turret_ctl),
    .goal_i   (tgt_q),
    .period_i (turret_period_q),
    .step_o   (turr_step),
    .dir_o    (turr_dir),
    .done_o   (turret_done),
    .pos_o    (turret_pos)
  );

  // Axis state changes only on adv, which also loads the result word, so the
  // state registers hold exactly the word being presented.
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {7'd0, turret_pos, platter_pos, z_pos,
                            turret_done, platter_done, z_done,
                            turr_dir, turr_step, plat_dir, plat_step,
                            z_dir, z_step};

  a_fill_empty_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !out_v_q) |=> out_v_q)
    else $error("held word not moved into empty result slot");

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_v_q && out_v_q && !m_axis_tready_i))
    else $error("input stalled with room in the pipeline");

  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready_i) |=> (out_v_q && $stable(m_axis_tdata_o)))
    else $error("result word changed while stalled");

endmodule
